FILE: hw/rtl/nmea_rmc_sentence_parser_macros.svh
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef NMEA_RMC_SENTENCE_PARSER_MACROS_SVH
`define NMEA_RMC_SENTENCE_PARSER_MACROS_SVH

// cond must hold at every clock edge
`define NRMC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// ante implies cons in the same cycle
`define NRMC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define NRMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/nrmc_pkg.sv
`default_nettype none

package nrmc_pkg;

	localparam int BYTE_W          = 8;
	localparam int LIMIT_W         = 16;
	localparam int TWO_DIG_W       = 7;
	localparam int COORD_W         = 32;
	localparam int MAG_W           = COORD_W - 1;
	localparam int MAX_FIELD_CHARS = 16;
	localparam int FLEN_W          = $clog2(MAX_FIELD_CHARS + 1);
	localparam int BCD_DIGITS      = 6;
	localparam int BCD_W           = 4 * BCD_DIGITS;
	localparam int DCNT_W          = 3;
	localparam int HDR_LEN         = 6;
	localparam int HDR_IDX_W       = 3;

	localparam logic [LIMIT_W-1:0] SEARCH_LIMIT_RST = LIMIT_W'(1000);
	localparam logic [13:0]        COORD_SCALE      = 14'd10000;

	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
	localparam logic [BYTE_W-1:0] CH_V     = 8'h56;
	localparam logic [BYTE_W-1:0] CH_N     = 8'h4e;
	localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
	localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
	localparam logic [BYTE_W-1:0] CH_W     = 8'h57;

	localparam logic [BYTE_W-1:0] HDR_CHARS [HDR_LEN] =
		'{8'h47, 8'h4e, 8'h52, 8'h4d, 8'h43, 8'h2c};

	typedef enum logic [3:0] {
		PH_HUNT  = 4'd0,
		PH_TIME  = 4'd1,
		PH_STAT  = 4'd2,
		PH_LAT   = 4'd3,
		PH_NS    = 4'd4,
		PH_LON   = 4'd5,
		PH_EW    = 4'd6,
		PH_SKIP1 = 4'd7,
		PH_SKIP2 = 4'd8,
		PH_DATE  = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		SG_NONE = 2'd0,
		SG_POS  = 2'd1,
		SG_NEG  = 2'd2
	} sign_t;

	typedef struct packed {
		logic                        status;
		logic                        time_valid;
		logic                        position_valid;
		logic                        date_valid;
		logic [TWO_DIG_W-1:0]        hour;
		logic [TWO_DIG_W-1:0]        minute;
		logic [TWO_DIG_W-1:0]        second;
		logic [TWO_DIG_W-1:0]        day;
		logic [TWO_DIG_W-1:0]        month;
		logic [TWO_DIG_W-1:0]        year;
		logic signed [COORD_W-1:0]   latitude;
		logic signed [COORD_W-1:0]   longitude;
	} result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nrmc_if.sv
`default_nettype none

interface nrmc_rx_if import nrmc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrmc_fix_if import nrmc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      status;
	logic                      time_valid;
	logic                      position_valid;
	logic                      date_valid;
	logic [TWO_DIG_W-1:0]      hour;
	logic [TWO_DIG_W-1:0]      minute;
	logic [TWO_DIG_W-1:0]      second;
	logic [TWO_DIG_W-1:0]      day;
	logic [TWO_DIG_W-1:0]      month;
	logic [TWO_DIG_W-1:0]      year;
	logic signed [COORD_W-1:0] latitude;
	logic signed [COORD_W-1:0] longitude;

	modport source (
		output valid, status, time_valid, position_valid, date_valid,
		output hour, minute, second, day, month, year, latitude, longitude,
		input ready
	);
	modport sink (
		input valid, status, time_valid, position_valid, date_valid,
		input hour, minute, second, day, month, year, latitude, longitude,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/nmea_rmc_sentence_parser.sv
// A result becomes valid once the item that closes it has passed the input register,
// then the parse logic into the result register.
// Throughput: one item per cycle; the input stage stalls only while a result is held.
// The combinational parse step (digit accumulate, one 31x14 scale multiply) sets this rate.
// Reset: all parse state cleared, header hunt restarts, search_limit returns to 1000.
`default_nettype none

`include "nmea_rmc_sentence_parser_macros.svh"

module nmea_rmc_sentence_parser import nrmc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata,
	nrmc_rx_if.sink                 rx,
	nrmc_fix_if.source              fix
);

	function automatic logic [TWO_DIG_W-1:0] two_dig(input logic [7:0] bcd);
		logic [TWO_DIG_W-1:0] hi;
		logic [TWO_DIG_W-1:0] lo;
		hi = TWO_DIG_W'(bcd[7:4]);
		lo = TWO_DIG_W'(bcd[3:0]);
		return TWO_DIG_W'((hi << 3) + (hi << 1) + lo);
	endfunction

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// state
	logic [LIMIT_W-1:0]   search_limit_q;
	phase_t               phase_q,     phase_n;
	logic [HDR_IDX_W-1:0] hdr_idx_q,   hdr_idx_n;
	logic [LIMIT_W-1:0]   search_cnt_q, search_cnt_n;
	logic [FLEN_W-1:0]    flen_q,      flen_n;
	logic [MAG_W-1:0]     acc_q,       acc_n;
	logic                 dig_end_q,   dig_end_n;
	logic [COORD_W-1:0]   scaled_q,    scaled_n;
	logic                 dot_seen_q,  dot_seen_n;
	logic                 ferr_q,      ferr_n;
	logic [DCNT_W-1:0]    dcnt_q,      dcnt_n;
	logic [BCD_W-1:0]     bcd_q,       bcd_n;
	logic                 time_ok_q,   time_ok_n;
	logic [TWO_DIG_W-1:0] hour_q,      hour_n;
	logic [TWO_DIG_W-1:0] min_q,       min_n;
	logic [TWO_DIG_W-1:0] sec_q,       sec_n;
	logic [MAG_W-1:0]     lat_q,       lat_n;
	logic [MAG_W-1:0]     lon_q,       lon_n;
	sign_t                lat_sign_q,  lat_sign_n;
	sign_t                lon_sign_q,  lon_sign_n;
	logic                 pos_ok_q,    pos_ok_n;

	// result register
	logic    out_valid_q;
	result_t res_q;
	result_t res_n;
	logic    emit;
	logic    fire;
	logic    clr;

	// per-character helpers
	logic                 is_dig;
	logic [3:0]           dval;
	logic [MAG_W+3:0]     acc_x10;
	logic [MAG_W-1:0]     acc_dig;
	logic [DCNT_W-1:0]    dcnt_inc;
	logic [MAG_W+13:0]    scale_mul;
	logic [COORD_W-1:0]   scale_sat;
	logic [COORD_W:0]     coord_sum;
	logic [MAG_W-1:0]     coord_val;
	logic [LIMIT_W-1:0]   cnt_inc;
	logic [HDR_IDX_W-1:0] idx_adv;
	logic                 date_ok;
	logic                 tok;
	logic [COORD_W-1:0]   lat_signed;
	logic [COORD_W-1:0]   lon_signed;

	assign fire     = valid_s1 && (!out_valid_q || fix.ready);
	assign rx.ready = !valid_s1 || fire;

	assign is_dig    = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign dval      = byte_s1[3:0];
	assign acc_x10   = (MAG_W+4)'({acc_q, 3'b000}) + (MAG_W+4)'({acc_q, 1'b0})
		+ (MAG_W+4)'(dval);
	assign acc_dig   = (|acc_x10[MAG_W+3:MAG_W]) ? '1 : acc_x10[MAG_W-1:0];
	assign dcnt_inc  = (&dcnt_q) ? dcnt_q : dcnt_q + DCNT_W'(1);
	assign scale_mul = (MAG_W+14)'(acc_q) * (MAG_W+14)'(COORD_SCALE);
	assign scale_sat = (|scale_mul[MAG_W+13:MAG_W]) ? {1'b1, {MAG_W{1'b0}}}
		: {1'b0, scale_mul[MAG_W-1:0]};
	assign coord_sum = {1'b0, scaled_q} + (COORD_W+1)'(acc_q);
	assign coord_val = (|coord_sum[COORD_W:MAG_W]) ? '1 : coord_sum[MAG_W-1:0];
	assign cnt_inc   = (&search_cnt_q) ? search_cnt_q : search_cnt_q + LIMIT_W'(1);
	assign date_ok   = !ferr_q && (dcnt_q != '0) && (dcnt_q <= DCNT_W'(BCD_DIGITS));
	assign tok       = date_ok;
	assign lat_signed = (lat_sign_q == SG_NEG) ? -{1'b0, lat_q} : {1'b0, lat_q};
	assign lon_signed = (lon_sign_q == SG_NEG) ? -{1'b0, lon_q} : {1'b0, lon_q};

	always_comb begin
		phase_n      = phase_q;
		hdr_idx_n    = hdr_idx_q;
		search_cnt_n = search_cnt_q;
		flen_n       = flen_q;
		acc_n        = acc_q;
		dig_end_n    = dig_end_q;
		scaled_n     = scaled_q;
		dot_seen_n   = dot_seen_q;
		ferr_n       = ferr_q;
		dcnt_n       = dcnt_q;
		bcd_n        = bcd_q;
		time_ok_n    = time_ok_q;
		hour_n       = hour_q;
		min_n        = min_q;
		sec_n        = sec_q;
		lat_n        = lat_q;
		lon_n        = lon_q;
		lat_sign_n   = lat_sign_q;
		lon_sign_n   = lon_sign_q;
		pos_ok_n     = pos_ok_q;
		res_n        = '0;
		emit         = 1'b0;
		clr          = 1'b0;
		idx_adv      = '0;

		if (fire) begin
			if (phase_q == PH_HUNT) begin
				search_cnt_n = cnt_inc;
				if (byte_s1 == HDR_CHARS[hdr_idx_q]) begin
					idx_adv = hdr_idx_q + HDR_IDX_W'(1);
				end else if (byte_s1 == HDR_CHARS[0]) begin
					idx_adv = HDR_IDX_W'(1);
				end
				hdr_idx_n = idx_adv;
				if (idx_adv == HDR_IDX_W'(HDR_LEN)) begin
					hdr_idx_n    = '0;
					search_cnt_n = '0;
					phase_n      = PH_TIME;
					clr          = 1'b1;
					time_ok_n    = 1'b0;
					pos_ok_n     = 1'b0;
					lat_sign_n   = SG_NONE;
					lon_sign_n   = SG_NONE;
				end else if (cnt_inc >= search_limit_q) begin
					hdr_idx_n    = '0;
					search_cnt_n = '0;
					emit         = 1'b1;
					res_n.status = 1'b1;
				end
			end else if (byte_s1 != CH_COMMA) begin
				if (flen_q >= FLEN_W'(MAX_FIELD_CHARS)) begin
					ferr_n = 1'b1;
				end else begin
					flen_n = flen_q + FLEN_W'(1);
				end
				if (!ferr_n) begin
					unique case (phase_q)
						PH_TIME, PH_DATE, PH_LAT, PH_LON: begin
							if ((phase_q == PH_LAT || phase_q == PH_LON)
									&& byte_s1 == CH_DOT) begin
								if (!dot_seen_q) begin
									scaled_n   = scale_sat;
									acc_n      = '0;
									dcnt_n     = '0;
									dig_end_n  = 1'b0;
									dot_seen_n = 1'b1;
								end else begin
									ferr_n = 1'b1;
								end
							end else if (!dig_end_q && is_dig) begin
								acc_n  = acc_dig;
								dcnt_n = dcnt_inc;
								bcd_n  = {bcd_q[BCD_W-5:0], dval};
							end else begin
								dig_end_n = 1'b1;
							end
						end
						PH_STAT: begin
							if (flen_q != '0 || (byte_s1 != CH_A && byte_s1 != CH_V)) begin
								ferr_n = 1'b1;
							end
						end
						PH_NS: begin
							if (flen_q == '0 && byte_s1 == CH_N) begin
								lat_sign_n = SG_POS;
							end else if (flen_q == '0 && byte_s1 == CH_S) begin
								lat_sign_n = SG_NEG;
							end else begin
								lat_sign_n = SG_NONE;
								ferr_n     = 1'b1;
							end
						end
						PH_EW: begin
							if (flen_q == '0 && byte_s1 == CH_E) begin
								lon_sign_n = SG_POS;
							end else if (flen_q == '0 && byte_s1 == CH_W) begin
								lon_sign_n = SG_NEG;
							end else begin
								lon_sign_n = SG_NONE;
								ferr_n     = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end else begin
				clr     = 1'b1;
				phase_n = phase_t'(4'(phase_q) + 4'd1);
				unique case (phase_q)
					PH_TIME: begin
						time_ok_n = tok;
						hour_n    = tok ? two_dig(bcd_q[23:16]) : '0;
						min_n     = tok ? two_dig(bcd_q[15:8])  : '0;
						sec_n     = tok ? two_dig(bcd_q[7:0])   : '0;
					end
					PH_STAT: begin
						time_ok_n = time_ok_q && !ferr_q && (flen_q == FLEN_W'(1));
					end
					PH_LAT: begin
						pos_ok_n = !ferr_q && (dcnt_q != '0);
						lat_n    = coord_val;
					end
					PH_NS: begin
						if (ferr_q || flen_q != FLEN_W'(1)) begin
							lat_sign_n = SG_NONE;
						end
						pos_ok_n = pos_ok_q && (lat_sign_n != SG_NONE);
					end
					PH_LON: begin
						pos_ok_n = pos_ok_q && !ferr_q && (dcnt_q != '0);
						lon_n    = coord_val;
					end
					PH_EW: begin
						if (ferr_q || flen_q != FLEN_W'(1)) begin
							lon_sign_n = SG_NONE;
						end
						pos_ok_n = pos_ok_q && (lon_sign_n != SG_NONE);
					end
					PH_DATE: begin
						phase_n              = PH_HUNT;
						hdr_idx_n            = '0;
						search_cnt_n         = '0;
						emit                 = 1'b1;
						res_n.status         = 1'b0;
						res_n.time_valid     = time_ok_q;
						res_n.position_valid = pos_ok_q;
						res_n.date_valid     = date_ok;
						res_n.hour           = time_ok_q ? hour_q : '0;
						res_n.minute         = time_ok_q ? min_q  : '0;
						res_n.second         = time_ok_q ? sec_q  : '0;
						res_n.day            = date_ok ? two_dig(bcd_q[23:16]) : '0;
						res_n.month          = date_ok ? two_dig(bcd_q[15:8])  : '0;
						res_n.year           = date_ok ? two_dig(bcd_q[7:0])   : '0;
						res_n.latitude       = pos_ok_q ? lat_signed : '0;
						res_n.longitude      = pos_ok_q ? lon_signed : '0;
					end
					default: begin
					end
				endcase
			end
		end

		if (clr) begin
			flen_n     = '0;
			acc_n      = '0;
			dig_end_n  = 1'b0;
			scaled_n   = '0;
			dot_seen_n = 1'b0;
			ferr_n     = 1'b0;
			dcnt_n     = '0;
			bcd_n      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			search_limit_q <= SEARCH_LIMIT_RST;
			phase_q        <= PH_HUNT;
			hdr_idx_q      <= '0;
			search_cnt_q   <= '0;
			flen_q         <= '0;
			acc_q          <= '0;
			dig_end_q      <= 1'b0;
			scaled_q       <= '0;
			dot_seen_q     <= 1'b0;
			ferr_q         <= 1'b0;
			dcnt_q         <= '0;
			bcd_q          <= '0;
			time_ok_q      <= 1'b0;
			hour_q         <= '0;
			min_q          <= '0;
			sec_q          <= '0;
			lat_q          <= '0;
			lon_q          <= '0;
			lat_sign_q     <= SG_NONE;
			lon_sign_q     <= SG_NONE;
			pos_ok_q       <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (fix.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				search_limit_q <= cfg_wdata;
			end
			phase_q      <= phase_n;
			hdr_idx_q    <= hdr_idx_n;
			search_cnt_q <= search_cnt_n;
			flen_q       <= flen_n;
			acc_q        <= acc_n;
			dig_end_q    <= dig_end_n;
			scaled_q     <= scaled_n;
			dot_seen_q   <= dot_seen_n;
			ferr_q       <= ferr_n;
			dcnt_q       <= dcnt_n;
			bcd_q        <= bcd_n;
			time_ok_q    <= time_ok_n;
			hour_q       <= hour_n;
			min_q        <= min_n;
			sec_q        <= sec_n;
			lat_q        <= lat_n;
			lon_q        <= lon_n;
			lat_sign_q   <= lat_sign_n;
			lon_sign_q   <= lon_sign_n;
			pos_ok_q     <= pos_ok_n;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
		if (emit) begin
			res_q <= res_n;
		end
	end

	assign fix.valid          = out_valid_q;
	assign fix.status         = res_q.status;
	assign fix.time_valid     = res_q.time_valid;
	assign fix.position_valid = res_q.position_valid;
	assign fix.date_valid     = res_q.date_valid;
	assign fix.hour           = res_q.hour;
	assign fix.minute         = res_q.minute;
	assign fix.second         = res_q.second;
	assign fix.day            = res_q.day;
	assign fix.month          = res_q.month;
	assign fix.year           = res_q.year;
	assign fix.latitude       = res_q.latitude;
	assign fix.longitude      = res_q.longitude;

	`NRMC_ASSERT_IMPL(a_notfound_clean, fix.valid && fix.status,
		!fix.time_valid && !fix.position_valid && !fix.date_valid
		&& fix.latitude == 0 && fix.longitude == 0 && fix.hour == 0,
		"not-found result carries data")
	`NRMC_ASSERT_IMPL(a_pos_zero, fix.valid && !fix.position_valid,
		fix.latitude == 0 && fix.longitude == 0, "invalid position not zeroed")
	`NRMC_ASSERT_IMPL(a_time_range, fix.valid && fix.time_valid,
		fix.hour <= 99 && fix.minute <= 99 && fix.second <= 99, "time digit out of range")
	`NRMC_ASSERT_IMPL(a_count_idle, phase_q != PH_HUNT,
		search_cnt_q == 0 && hdr_idx_q == 0, "hunt state live during field parse")
	`NRMC_ASSERT_NEXT(a_s1_hold, valid_s1 && !fire,
		valid_s1 && $stable(byte_s1), "input stage lost a stalled item")

endmodule

`default_nettype wire
